// ===== rtl/core/sha1bsh_pkg.sv =====
// Shared types and constants for the SHA-1 byte stream hasher.
package sha1bsh_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ROUND,
    ST_FOLD,
    ST_OUT
  } state_t;

  localparam int unsigned NUM_ROUNDS  = 80;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned HASH_WORDS  = 5;

  localparam logic [2:0] LAST_WORD_IDX = 3'd4;
  localparam logic [5:0] LAST_BYTE_POS = 6'd63;
  localparam logic [5:0] LEN_SPILL_POS = 6'd56;
  localparam logic [6:0] LAST_ROUND    = 7'd79;

  localparam logic [7:0] PAD_BYTE = 8'h80;

  localparam logic [31:0] K0 = 32'h5A827999;
  localparam logic [31:0] K1 = 32'h6ED9EBA1;
  localparam logic [31:0] K2 = 32'h8F1BBCDC;
  localparam logic [31:0] K3 = 32'hCA62C1D6;

  localparam logic [31:0] H_INIT [HASH_WORDS] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };

endpackage

// ===== rtl/core/sha1_byte_stream_hasher_core.sv =====
// SHA-1 hasher top level: byte packing, padding and one round per cycle.
// Sequence: absorb bytes are taken while idle; the 64th byte of a block starts the
//   rounds and then a fold into the chaining hash. A finish pads and compresses (twice when the
//   pad spills into a second block), then five digest transfers, one per cycle unless out_stall holds them.
// No new byte is taken while a block compresses or the digest is out; one shared round unit.
// Reset: synchronous, active high; loads the initial hash, clears length and position.
module sha1_byte_stream_hasher_core (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        mode,
  input  logic [7:0]  message_byte,
  // digest channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] digest_word,
  output logic [2:0]  word_index,
  output logic        last_word
);
  import sha1bsh_pkg::*;

  state_t state, state_next;

  // Chaining hash, read at one address for the digest output.
  logic [31:0] chain_hash [HASH_WORDS];
  // Block buffer doubles as the message schedule window during compression:
  // word 0 is always the current round's W, new words enter at word 15.
  logic [31:0] win [BLOCK_WORDS];
  logic [63:0] bit_count;
  logic [5:0]  byte_position;

  // Working variables of the round unit.
  logic [31:0] a, b, c, d, e;
  logic [6:0]  round;
  logic        more_block;   // pad spilled: a second block follows
  logic        finishing;    // current compression belongs to a finish
  logic [2:0]  out_idx;

  // Absorb/pad byte placement: word index and bit offset of the byte lane.
  logic [3:0]  put_idx;
  logic [4:0]  put_shift;
  logic [7:0]  put_data;

  // Round unit.
  logic [31:0] f, k, t, w_new;
  logic [31:0] h_sum [HASH_WORDS];

  assign put_idx   = byte_position[5:2];
  assign put_shift = {~byte_position[1:0], 3'b000};
  assign put_data  = mode ? PAD_BYTE : message_byte;

  always_comb begin
    if (round < 7'd20) begin
      f = d ^ (b & (c ^ d));
      k = K0;
    end else if (round < 7'd40) begin
      f = b ^ c ^ d;
      k = K1;
    end else if (round < 7'd60) begin
      f = (b & c) | (d & (b | c));
      k = K2;
    end else begin
      f = b ^ c ^ d;
      k = K3;
    end
  end

  assign t     = {a[26:0], a[31:27]} + f + e + k + win[0];
  // Schedule word for round+16, shifted into the tail of the window.
  assign w_new = {win[13][30:0] ^ win[8][30:0] ^ win[2][30:0] ^ win[0][30:0],
                  win[13][31] ^ win[8][31] ^ win[2][31] ^ win[0][31]};

  assign h_sum[0] = chain_hash[0] + a;
  assign h_sum[1] = chain_hash[1] + b;
  assign h_sum[2] = chain_hash[2] + c;
  assign h_sum[3] = chain_hash[3] + d;
  assign h_sum[4] = chain_hash[4] + e;

  // Sequencer state register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Next state and handshake outputs.
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    out_valid  = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid && (mode || byte_position == LAST_BYTE_POS)) begin
          state_next = ST_ROUND;
        end
      end
      ST_ROUND: begin
        if (round == LAST_ROUND) begin
          state_next = ST_FOLD;
        end
      end
      ST_FOLD: begin
        if (more_block) begin
          state_next = ST_ROUND;
        end else if (finishing) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_OUT: begin
        out_valid = 1'b1;
        if (!out_stall && out_idx == LAST_WORD_IDX) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // Control state: hash, length, position and sequencing flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HASH_WORDS; i++) begin
        chain_hash[i] <= H_INIT[i];
      end
      bit_count     <= '0;
      byte_position <= '0;
      round         <= '0;
      more_block    <= 1'b0;
      finishing     <= 1'b0;
      out_idx       <= '0;
    end else begin
      case (state)
        ST_IDLE: begin
          round <= '0;
          if (in_valid) begin
            if (!mode) begin
              bit_count     <= bit_count + 64'd8;
              byte_position <= byte_position + 6'd1;
              more_block    <= 1'b0;
              finishing     <= 1'b0;
            end else begin
              more_block <= (byte_position >= LEN_SPILL_POS);
              finishing  <= 1'b1;
            end
          end
        end
        ST_ROUND: begin
          round <= round + 7'd1;
        end
        ST_FOLD: begin
          for (int i = 0; i < HASH_WORDS; i++) begin
            chain_hash[i] <= h_sum[i];
          end
          round      <= '0;
          more_block <= 1'b0;
          out_idx    <= '0;
        end
        ST_OUT: begin
          if (!out_stall) begin
            if (out_idx == LAST_WORD_IDX) begin
              // message done: back to the initial state
              for (int i = 0; i < HASH_WORDS; i++) begin
                chain_hash[i] <= H_INIT[i];
              end
              bit_count     <= '0;
              byte_position <= '0;
              finishing     <= 1'b0;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          round <= '0;
        end
      endcase
    end
  end

  // Payload: block buffer and round working variables, no reset needed.
  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          // A byte that starts a word clears the rest of it.
          if (byte_position[1:0] == 2'b00) begin
            win[put_idx] <= {put_data, 24'd0};
          end else begin
            win[put_idx][put_shift +: 8] <= put_data;
          end
          if (mode) begin
            // words after the pad: zeros, or the length when it still fits
            for (int i = 0; i < BLOCK_WORDS; i++) begin
              if (4'(i) > put_idx) begin
                if (byte_position < LEN_SPILL_POS && i == BLOCK_WORDS - 2) begin
                  win[i] <= bit_count[63:32];
                end else if (byte_position < LEN_SPILL_POS && i == BLOCK_WORDS - 1) begin
                  win[i] <= bit_count[31:0];
                end else begin
                  win[i] <= '0;
                end
              end
            end
          end
          a <= chain_hash[0];
          b <= chain_hash[1];
          c <= chain_hash[2];
          d <= chain_hash[3];
          e <= chain_hash[4];
        end
      end
      ST_ROUND: begin
        for (int i = 0; i < BLOCK_WORDS - 1; i++) begin
          win[i] <= win[i+1];
        end
        win[BLOCK_WORDS-1] <= w_new;
        e <= d;
        d <= c;
        c <= {b[1:0], b[31:2]};
        b <= a;
        a <= t;
      end
      ST_FOLD: begin
        if (more_block) begin
          // length-only block after a spilled pad
          for (int i = 0; i < BLOCK_WORDS - 2; i++) begin
            win[i] <= '0;
          end
          win[BLOCK_WORDS-2] <= bit_count[63:32];
          win[BLOCK_WORDS-1] <= bit_count[31:0];
          a <= h_sum[0];
          b <= h_sum[1];
          c <= h_sum[2];
          d <= h_sum[3];
          e <= h_sum[4];
        end
      end
      default: begin
        a <= a;
      end
    endcase
  end

  assign digest_word = chain_hash[out_idx];
  assign word_index  = out_idx;
  assign last_word   = (out_idx == LAST_WORD_IDX);

endmodule

// ===== rtl/core/sha1bsh_checker.sv =====
// Port-level checker for the SHA-1 hasher, bound to the top level.
module sha1bsh_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        mode,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  word_index,
  input logic        last_word
);

  // The block takes no input while digest words are pending.
  a_idle_no_out: assert property (@(posedge clk) disable iff (rst)
    !in_stall |-> !out_valid)
    else $error("input ready while digest pending");

  a_last_index: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd4)))
    else $error("last_word out of step with word_index");

  a_burst: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !last_word |=>
      out_valid && word_index == $past(word_index) + 3'd1)
    else $error("digest burst broken");

  a_back_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_word |=> !in_stall && !out_valid)
    else $error("not idle after final digest word");

  a_finish_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && mode |=> in_stall)
    else $error("finish transfer did not start padding");

endmodule

bind sha1_byte_stream_hasher_core sha1bsh_checker u_sha1bsh_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .mode       (mode),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .word_index (word_index),
  .last_word  (last_word)
);

// ===== sim/sha1_byte_stream_hasher_core_test.sv =====
// Self-checking testbench for the SHA-1 byte stream hasher core.
`timescale 1ns / 1ps

module sha1_byte_stream_hasher_core_test;

  // Input transfer kinds
  localparam logic MODE_ABSORB = 1'b0;
  localparam logic MODE_FINISH = 1'b1;

  // SHA-1 constants, kept local so a bad constant in the design is caught
  localparam logic [31:0] RK0 = 32'h5A827999;
  localparam logic [31:0] RK1 = 32'h6ED9EBA1;
  localparam logic [31:0] RK2 = 32'h8F1BBCDC;
  localparam logic [31:0] RK3 = 32'hCA62C1D6;
  localparam logic [31:0] IV [5] = '{
    32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
  };
  localparam logic [7:0] PAD_MARK   = 8'h80;
  localparam int         FINAL_WORD = 4;
  localparam logic [5:0] SPILL_POS  = 6'd56;

  localparam int CYCLE_LIMIT   = 300000;
  localparam int SETTLE_CYCLES = 200;   // > worst finish, which has a spilled pad
  localparam int REPORT_MAX    = 10;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last_flag;
  } digest_rec_t;

  logic        clk          = 1'b0;
  logic        rst          = 1'b1;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic        mode         = MODE_ABSORB;
  logic [7:0]  message_byte = 8'h00;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  // Hash model state
  logic [31:0] chain_hv [5];
  logic [31:0] blk_words [16];
  logic [63:0] msg_bits;
  logic [5:0]  fill_pos;

  digest_rec_t pending_digest [$];

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int items_sent     = 0;
  int mismatch_count = 0;
  int cycle_count    = 0;

  sha1_byte_stream_hasher_core DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .mode         (mode),
    .message_byte (message_byte),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .digest_word  (digest_word),
    .word_index   (word_index),
    .last_word    (last_word)
  );

  // 12 ns clock
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Watchdog: a hung handshake ends the run as a failure
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Receiver back-pressure, redrawn every cycle
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // ---------------------------------------------------------------------------
  // Hash model
  // ---------------------------------------------------------------------------

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void init_hash_model();
    chain_hv  = IV;
    blk_words = '{default: 32'h0};
    msg_bits  = 64'h0;
    fill_pos  = 6'd0;
  endfunction

  // 80 rounds over blk_words, folded into chain_hv
  function automatic void sha1_compress();
    logic [31:0] w [16];
    logic [31:0] a, b, c, d, e, f, k, wr, t;
    w = blk_words;
    a = chain_hv[0];
    b = chain_hv[1];
    c = chain_hv[2];
    d = chain_hv[3];
    e = chain_hv[4];
    for (int r = 0; r < 80; r++) begin
      if (r < 16) begin
        wr = w[r];
      end else begin
        wr = rol(w[(r + 13) & 15] ^ w[(r + 8) & 15] ^ w[(r + 2) & 15] ^ w[r & 15], 1);
        w[r & 15] = wr;
      end
      if (r < 20) begin
        f = d ^ (b & (c ^ d));
        k = RK0;
      end else if (r < 40) begin
        f = b ^ c ^ d;
        k = RK1;
      end else if (r < 60) begin
        f = (b & c) | (d & (b | c));
        k = RK2;
      end else begin
        f = b ^ c ^ d;
        k = RK3;
      end
      t = rol(a, 5) + f + e + k + wr;
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = t;
    end
    chain_hv[0] += a;
    chain_hv[1] += b;
    chain_hv[2] += c;
    chain_hv[3] += d;
    chain_hv[4] += e;
  endfunction

  // Big-endian packing; the first byte of a word clears the rest of it
  function automatic void place_byte(input logic [5:0] pos, input logic [7:0] b);
    int idx;
    idx = pos[5:2];
    if (pos[1:0] == 2'd0) blk_words[idx] = 32'h0;
    blk_words[idx][(3 - pos[1:0]) * 8 +: 8] = b;
  endfunction

  // Advance the model by one accepted input transfer
  function automatic void update_digest_model(input logic m, input logic [7:0] b);
    digest_rec_t rec;
    if (m == MODE_ABSORB) begin
      place_byte(fill_pos, b);
      msg_bits += 64'd8;
      fill_pos += 6'd1;
      if (fill_pos == 6'd0) sha1_compress();
    end else begin
      place_byte(fill_pos, PAD_MARK);
      for (int i = fill_pos[5:2] + 1; i < 16; i++) blk_words[i] = 32'h0;
      // no room left for the length: pad spills into a second block
      if (fill_pos >= SPILL_POS) begin
        sha1_compress();
        blk_words = '{default: 32'h0};
      end
      blk_words[14] = msg_bits[63:32];
      blk_words[15] = msg_bits[31:0];
      sha1_compress();
      for (int i = 0; i < 5; i++) begin
        rec.word      = chain_hv[i];
        rec.index     = 3'(i);
        rec.last_flag = (i == FINAL_WORD);
        pending_digest.push_back(rec);
      end
      init_hash_model();
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Digest checking
  // ---------------------------------------------------------------------------

  function automatic void note_failure(input string msg);
    mismatch_count++;
    if (mismatch_count <= REPORT_MAX) $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
  endfunction

  always @(posedge clk) begin : digest_check
    digest_rec_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_digest.size() == 0) begin
        note_failure($sformatf("unexpected transfer: word %h index %0d last %b",
                               digest_word, word_index, last_word));
      end else begin
        want = pending_digest.pop_front();
        if (digest_word !== want.word)
          note_failure($sformatf("digest_word: expected %h, got %h", want.word, digest_word));
        if (word_index !== want.index)
          note_failure($sformatf("word_index: expected %0d, got %0d", want.index, word_index));
        if (last_word !== want.last_flag)
          note_failure($sformatf("last_word: expected %b, got %b", want.last_flag, last_word));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // One input transfer; valid stays high on return so back-to-back items
  // need no gap
  task automatic send_item(input logic m, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    mode         <= m;
    message_byte <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    update_digest_model(m, b);
    items_sent++;
  endtask

  // Random content of the given length, then a finish with a junk byte
  task automatic send_message(input int len);
    for (int i = 0; i < len; i++) send_item(MODE_ABSORB, 8'($urandom_range(255)));
    send_item(MODE_FINISH, 8'($urandom_range(255)));
  endtask

  // Sender holds off until every digest word has been collected
  task automatic drain_digests();
    in_valid <= 1'b0;
    while (pending_digest.size() != 0) @(posedge clk);
  endtask

  // Mostly short messages for plenty of digests, with a good share sitting
  // on the pad-spill and full-block edges
  function automatic int pick_length();
    int roll;
    int edges [8] = '{54, 55, 56, 57, 62, 63, 64, 65};
    roll = $urandom_range(99);
    if (roll < 45) return $urandom_range(6);
    if (roll < 80) return edges[$urandom_range(7)];
    return $urandom_range(140);
  endfunction

  // Digest of the empty message, straight after reset and back to back
  task automatic test_empty_message();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    send_item(MODE_FINISH, 8'hFF);
    send_item(MODE_FINISH, 8'h00);
    drain_digests();
  endtask

  // Known text plus byte extremes, each hashed separately
  task automatic test_short_messages();
    send_item(MODE_ABSORB, 8'h61);
    send_item(MODE_ABSORB, 8'h62);
    send_item(MODE_ABSORB, 8'h63);
    send_item(MODE_FINISH, 8'hA5);
    send_item(MODE_ABSORB, 8'h00);
    send_item(MODE_ABSORB, 8'hFF);
    send_item(MODE_ABSORB, PAD_MARK);
    send_item(MODE_FINISH, 8'h5A);
    send_item(MODE_ABSORB, 8'hFF);
    send_item(MODE_FINISH, 8'h01);
    drain_digests();
  endtask

  // Random messages under one idling mix; lead_len forces a block edge case.
  // The last message is trimmed so the phase sends exactly budget items.
  task automatic test_random_traffic(input int lead_len, input int idle_pct,
                                     input int hold_pct, input int budget);
    int first;
    int len;
    send_idle_pct  = idle_pct;
    recv_stall_pct = hold_pct;
    first          = items_sent;
    send_message(lead_len);
    while (items_sent - first < budget) begin
      len = pick_length();
      if (len > budget - (items_sent - first) - 1) len = budget - (items_sent - first) - 1;
      send_message(len);
    end
    drain_digests();
  endtask

  initial begin
    init_hash_model();
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    test_empty_message();
    test_short_messages();
    // 56 and 63 bytes spill the pad, 64 leaves a pad-only block, 55 just fits
    test_random_traffic(56, 0, 0, 92);
    test_random_traffic(64, 69, 0, 92);
    test_random_traffic(63, 0, 69, 92);
    test_random_traffic(55, 6, 6, 92);

    drain_digests();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_digest.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

// ===== sha1_byte_stream_hasher_core.f =====
rtl/core/sha1bsh_pkg.sv
rtl/core/sha1_byte_stream_hasher_core.sv
rtl/core/sha1bsh_checker.sv
sim/sha1_byte_stream_hasher_core_test.sv
